// ===== rtl/kjd_pkg.sv =====
package kjd_pkg;

  // Defaults for the top-level parameters
  localparam int WINDOW_MAX_DEF  = 8;
  localparam int HEIGHT_BITS_DEF = 16;

  // Cost path
  localparam int                COST_W   = 32;
  localparam logic [COST_W-1:0] COST_TOP = '1;

  // Register file
  localparam int                    MAX_JUMP_W   = 4;
  localparam logic [MAX_JUMP_W-1:0] MAX_JUMP_RST = 4'd1;
  localparam int                    PADDR_W      = 3;
  localparam int                    PDATA_W      = 32;
  localparam logic [PADDR_W-1:0]    REG_MAX_JUMP_ADDR = 3'd0;

  // One result beat
  typedef struct packed {
    logic [COST_W-1:0] min_cost;
    logic              is_last;
  } res_t;

endpackage

// ===== rtl/kjd_cell.sv =====
module kjd_cell
  import kjd_pkg::*;
#(
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF,
  parameter int INDEX       = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   shift,
  input  logic                   clear,
  input  logic                   left_valid,
  input  logic [HEIGHT_BITS-1:0] left_height,
  input  logic [COST_W-1:0]      left_cost,
  input  logic [HEIGHT_BITS-1:0] cur_height,
  input  logic [MAX_JUMP_W-1:0]  max_jump,
  output logic                   valid,
  output logic [HEIGHT_BITS-1:0] height,
  output logic [COST_W-1:0]      cost,
  output logic                   cand_en,
  output logic [COST_W-1:0]      cand_cost
);

  logic [HEIGHT_BITS-1:0] diff;
  logic [COST_W:0]        sum;

  // Valid bit: one more stone of the window per shift, all dropped at end of sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (clear) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= left_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      height <= left_height;
      cost   <= left_cost;
    end
  end

  // Jump distance is INDEX+1; max_jump of zero still allows the nearest stone
  assign cand_en = valid && ((INDEX == 0) || (32'(INDEX) < 32'(max_jump)));

  always_comb begin
    diff = (cur_height >= height) ? (cur_height - height) : (height - cur_height);
    sum  = {1'b0, cost} + (COST_W + 1)'(diff);
    if (!cand_en) begin
      cand_cost = COST_TOP;
    end else if (sum[COST_W]) begin
      cand_cost = COST_TOP;
    end else begin
      cand_cost = sum[COST_W-1:0];
    end
  end

endmodule

// ===== rtl/kjd_out_buf.sv =====
module kjd_out_buf
  import kjd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  res_t push_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic skid_valid;
  res_t skid_data;
  logic out_fire;
  logic push_fire;

  assign push_ready = !skid_valid;
  assign out_fire   = out_valid && out_ready;
  assign push_fire  = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (push_fire) begin
      if (out_valid && !out_fire) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_data <= skid_data;
      end
    end else if (push_fire) begin
      if (out_valid && !out_fire) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

  // A held skid beat always sits behind a presented beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat with output empty");

endmodule

// ===== rtl/k_jump_min_cost_dp.sv =====
// k_jump_min_cost_dp: streaming minimum-cost frog jump, jumps of 1..max_jump stones.
// Input channel (in_valid/in_ready): one beat per stone, height plus last_stone.
// Output channel (out_valid/out_ready): one beat per stone, min_cost and is_last.
// Each result is the least total cost to reach the stone from the first stone of its
// sequence; a jump costs the absolute height difference, sums saturate at all ones.
// Each result is registered in the output buffer on its way to the output.
// Throughput: one stone per cycle while in_ready is high. The cost of a stone feeds the very next stone,
// so the cell compare and the min tree are combinational.
// A two-entry output buffer keeps in_ready registered; with the receiver stalled
// one more stone is taken, then in_ready drops until a beat leaves.
// The stone flagged last_stone closes the sequence and empties the window.
// APB register at byte 0: max_jump (4 bits, reset 1); 0 acts as 1, values above the
// window depth act as the depth. Write it only while the block is idle.
// Reset (rst, synchronous): empties the window and the output buffer and sets
// max_jump to 1; no clearing pass, the block is ready the cycle after reset.
module k_jump_min_cost_dp
  import kjd_pkg::*;
#(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // stone input
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [HEIGHT_BITS-1:0] height,
  input  logic                   last_stone,
  // result output
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COST_W-1:0]      min_cost,
  output logic                   is_last,
  // register port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]     prdata,
  output logic                   pready
);

  localparam int LEAVES = 1 << $clog2(WINDOW_MAX);

  logic [MAX_JUMP_W-1:0] max_jump;
  logic                  in_fire;
  logic                  clear;

  // Cell chain: cell 0 holds the newest stone
  logic                   vld  [WINDOW_MAX];
  logic [HEIGHT_BITS-1:0] hgt  [WINDOW_MAX];
  logic [COST_W-1:0]      cst  [WINDOW_MAX];
  logic [COST_W-1:0]      cand [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]  en_vec;
  logic [WINDOW_MAX-1:0]  vld_vec;

  logic [COST_W-1:0] node [1:2*LEAVES-1];
  logic [COST_W-1:0] best;

  res_t res_in;
  res_t res_out;

  // Register port: pready tied high, no wait states
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_jump <= MAX_JUMP_RST;
    end else if (psel && penable && pwrite && pready && (paddr == REG_MAX_JUMP_ADDR)) begin
      max_jump <= pwdata[MAX_JUMP_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr)
      REG_MAX_JUMP_ADDR: prdata = PDATA_W'(max_jump);
      default:           prdata = '0;
    endcase
  end

  assign in_fire = in_valid && in_ready;
  assign clear   = in_fire && last_stone;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic                   l_valid;
    logic [HEIGHT_BITS-1:0] l_height;
    logic [COST_W-1:0]      l_cost;

    if (i == 0) begin : g_head
      assign l_valid  = 1'b1;
      assign l_height = height;
      assign l_cost   = best;
    end else begin : g_link
      assign l_valid  = vld[i-1];
      assign l_height = hgt[i-1];
      assign l_cost   = cst[i-1];
    end

    kjd_cell #(
      .HEIGHT_BITS (HEIGHT_BITS),
      .INDEX       (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .shift       (in_fire),
      .clear       (clear),
      .left_valid  (l_valid),
      .left_height (l_height),
      .left_cost   (l_cost),
      .cur_height  (height),
      .max_jump    (max_jump),
      .valid       (vld[i]),
      .height      (hgt[i]),
      .cost        (cst[i]),
      .cand_en     (en_vec[i]),
      .cand_cost   (cand[i])
    );

    assign vld_vec[i] = vld[i];
  end

  // Min tree over the cell candidates; pad leaves read as saturated
  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < WINDOW_MAX) begin : g_used
      assign node[LEAVES+i] = cand[i];
    end else begin : g_pad
      assign node[LEAVES+i] = COST_TOP;
    end
  end

  for (genvar n = 1; n < LEAVES; n++) begin : g_node
    assign node[n] = (node[2*n] < node[2*n+1]) ? node[2*n] : node[2*n+1];
  end

  // No candidate at all: first stone of the sequence, cost zero
  assign best = (|en_vec) ? node[1] : '0;

  assign res_in.min_cost = best;
  assign res_in.is_last  = last_stone;

  kjd_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (res_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (res_out)
  );

  assign min_cost = res_out.min_cost;
  assign is_last  = res_out.is_last;

  // Window occupancy fills from cell 0 with no holes
  a_window_contig: assert property (@(posedge clk) disable iff (rst)
    (vld_vec & (vld_vec + 1'b1)) == '0)
    else $error("window valid bits not contiguous");

  // The last stone empties the window
  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_stone |=> vld_vec == '0)
    else $error("window not cleared after last stone");

  // First stone of a sequence costs nothing
  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    in_fire && !vld_vec[0] |-> best == '0)
    else $error("first stone cost not zero");

  // Reset brings max_jump back to its default
  a_reset_max_jump: assert property (@(posedge clk)
    rst |=> max_jump == MAX_JUMP_RST)
    else $error("max_jump not restored by reset");

endmodule
